[design/jfe_pkg.sv]
// Shared types and constants for the motion-JPEG frame extractor.
// Used by every module of the block; depends on nothing.
package jfe_pkg;

  localparam int unsigned CNT_W                   = 18;
  localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 131072;
  localparam int unsigned QDEPTH                  = 4;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 18'd81920;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_NO_FRAME  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             frame_first;
    logic             frame_last;
    status_t          status;
    logic [CNT_W-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic space2;
    logic nempty;
  } qstat_t;

endpackage

[design/jfe_front.sv]
// Front end: accepts stream transactions, tracks frame state and limit,
// and emits up to two results per transaction. Depends on jfe_pkg.
module jfe_front import jfe_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  output push_t            push
);

  logic [CNT_W-1:0] frame_limit_r;
  logic             in_frame_r, in_frame_nxt;
  logic             prev_ff_r, prev_ff_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] count_inc;

  always_comb begin
    limit = (32'(frame_limit_r) > MAX_FRAME_BYTES) ? CNT_W'(MAX_FRAME_BYTES) : frame_limit_r;
    count_inc = count_r + 1'b1;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_ff_nxt  = prev_ff_r;
    count_nxt    = count_r;
    push         = '0;
    if (acc) begin
      if (stream_end) begin
        push.n = 2'd1;
        push.r0.status     = in_frame_r ? ST_TRUNCATED : ST_NO_FRAME;
        push.r0.byte_count = in_frame_r ? count_r : '0;
        in_frame_nxt = 1'b0;
        prev_ff_nxt  = 1'b0;
        count_nxt    = '0;
      end else if (!in_frame_r) begin
        if (prev_ff_r && data_byte == MARK_SOI) begin
          push.n = 2'd2;
          push.r0 = '{out_byte: MARK_FF, frame_first: 1'b1, frame_last: 1'b0,
                      status: ST_DATA, byte_count: CNT_W'(1)};
          push.r1 = '{out_byte: MARK_SOI, frame_first: 1'b0, frame_last: 1'b0,
                      status: ST_DATA, byte_count: CNT_W'(2)};
          in_frame_nxt = 1'b1;
          prev_ff_nxt  = 1'b0;
          count_nxt    = CNT_W'(2);
        end else begin
          prev_ff_nxt = (data_byte == MARK_FF);
        end
      end else if (count_r >= limit) begin
        push.n = 2'd1;
        push.r0.status     = ST_OVERFLOW;
        push.r0.byte_count = count_r;
        in_frame_nxt = 1'b0;
        prev_ff_nxt  = 1'b0;
        count_nxt    = '0;
      end else begin
        push.n = 2'd1;
        push.r0.out_byte   = data_byte;
        push.r0.status     = ST_DATA;
        push.r0.byte_count = count_inc;
        if (prev_ff_r && data_byte == MARK_EOI) begin
          push.r0.frame_last = 1'b1;
          in_frame_nxt = 1'b0;
          prev_ff_nxt  = 1'b0;
          count_nxt    = '0;
        end else begin
          prev_ff_nxt = (data_byte == MARK_FF);
          count_nxt   = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r <= LIMIT_RESET;
      in_frame_r    <= 1'b0;
      prev_ff_r     <= 1'b0;
      count_r       <= '0;
    end else begin
      if (cfg_we) frame_limit_r <= cfg_data;
      in_frame_r <= in_frame_nxt;
      prev_ff_r  <= prev_ff_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

[design/jfe_queue.sv]
// Result queue between front and back: two writes, one read per cycle.
// Depends on jfe_pkg.
module jfe_queue import jfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output qstat_t  stat
);

  localparam int unsigned PW = $clog2(QDEPTH);

  result_t         mem [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]   wp_1;

  always_comb begin
    wp_1    = wp_r + 1'b1;
    wp_nxt  = wp_r + PW'(push.n);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + (PW+1)'(push.n) - (PW+1)'(pop);
    head    = mem[rp_r];
    stat.nempty = (cnt_r != '0);
    stat.space2 = (cnt_r <= (PW+1)'(QDEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp_r] <= push.r0;
    if (push.n == 2'd2) mem[wp_1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/jfe_back.sv]
// Back end: output register that drains the result queue onto the
// result channel. Depends on jfe_pkg.
module jfe_back import jfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  result_t head,
  input  qstat_t  stat,
  output logic    pop,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    pop       = stat.nempty && (!valid_r || out_ready);
    valid_nxt = pop || (valid_r && !out_ready);
    out_valid = valid_r;
    res       = res_r;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

endmodule

[design/jpeg_frame_extractor_unit.sv]
// Motion-JPEG frame extractor, top level.
// Input channel (in_*): one stream byte or a stream-end mark per transaction.
// Result channel (out_*): frame bytes with first/last flags, or a status
//   result (overflow, truncated, no frame) with the byte count reached.
// Config channel (cfg_*): writes frame_limit; always ready.
// Throughput: one input transaction per cycle while in_ready is high. A start
//   marker yields two results, so the result side sets the pace at one result
//   per cycle while out_ready is high. The front end writes each result into
//   the queue at the accepting edge; the output register then loads it from
//   the queue head when the back end pops it.
// A four-entry queue sits between front and back; in_ready drops while it
//   has fewer than two free entries, so a stalled receiver backs up the
//   input within a few transactions and nothing is lost.
// Reset: synchronous, active low; clears frame state, empties the queue and
//   sets frame_limit to 81920.
// Uses jfe_pkg, jfe_front, jfe_queue, jfe_back.
module jpeg_frame_extractor_unit import jfe_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_frame_limit,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_stream_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_first,
  output logic             out_frame_last,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_byte_count
);

  push_t   push;
  qstat_t  stat;
  result_t head;
  result_t res;
  logic    pop;
  logic    acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = stat.space2;
  assign acc       = in_valid && in_ready;

  jfe_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_frame_limit),
    .acc        (acc),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .push       (push)
  );

  jfe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  jfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_byte        = res.out_byte;
  assign out_frame_first = res.frame_first;
  assign out_frame_last  = res.frame_last;
  assign out_status      = res.status;
  assign out_byte_count  = res.byte_count;

  a_first_is_soi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_first) |->
      (out_byte == MARK_FF && out_byte_count == CNT_W'(1) && !out_frame_last))
    else $error("frame start result malformed");

  a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DATA) |->
      (out_byte == 8'h00 && !out_frame_first && !out_frame_last))
    else $error("status result carries data");

  a_last_is_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |-> (out_byte == MARK_EOI))
    else $error("frame end result not on end marker");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |-> (push.n == 2'd0))
    else $error("queue written without input transaction");

endmodule
